/* rtl/radix5_dft_butterfly_core_assert.svh */
// Assertion macros for the radix-5 butterfly core.
// Expects clk and arst_n in the scope of the including module.
`ifndef RADIX5_DFT_BUTTERFLY_CORE_ASSERT_SVH
`define RADIX5_DFT_BUTTERFLY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define R5_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define R5_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define R5_ASSERT(lbl, prop, msg)
`define R5_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/r5dft_pkg.sv */
// Widths, Q1.15 twiddle constants and rounding helpers of the radix-5 butterfly.
// No dependencies.
package r5dft_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int OUT_WIDTH    = 19;
	localparam int KW           = 16;
	localparam int QSHIFT       = 15;

	localparam int SW1 = SAMPLE_WIDTH + 1;
	localparam int SW2 = SAMPLE_WIDTH + 2;
	localparam int SW3 = SAMPLE_WIDTH + 3;
	localparam int AW  = SAMPLE_WIDTH + 4;
	localparam int PW  = SW2 + KW;
	localparam int RW  = PW - QSHIFT;
	localparam int EW  = (AW > OUT_WIDTH) ? AW : OUT_WIDTH;

	localparam logic signed [KW-1:0] K1 = KW'(18318);
	localparam logic signed [KW-1:0] K2 = KW'(31164);
	localparam logic signed [KW-1:0] K4 = KW'(19261);

	localparam logic signed [PW-1:0] QRND = PW'(1) << (QSHIFT - 1);

	function automatic logic signed [PW-1:0] kmul(input logic signed [SW2-1:0] v,
			input logic signed [KW-1:0] k);
		logic signed [PW-1:0] a;
		logic signed [PW-1:0] b;
		a = PW'(v);
		b = PW'(k);
		return a * b;
	endfunction

	function automatic logic signed [RW-1:0] qround(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] q;
		q = p + QRND;
		return q[PW-1:QSHIFT];
	endfunction

	function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [AW-1:0] v);
		logic signed [EW-1:0] e;
		e = EW'(v);
		return e[OUT_WIDTH-1:0];
	endfunction

endpackage

/* rtl/radix5_dft_butterfly_core.sv */
// Radix-5 forward DFT butterfly, five register stages.
// A beat taken into the first stage passes through stages two to five before it shows on the outputs.
// Throughput: one beat per cycle; an output stall holds the full stages back to the first
// empty one, which still fills.
// Reset (arst_n low, asynchronous) empties all stages; data registers keep values.
// Depends on r5dft_pkg and radix5_dft_butterfly_core_assert.svh.
`include "radix5_dft_butterfly_core_assert.svh"
module radix5_dft_butterfly_core
	import r5dft_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] x0_re,
	input  logic signed [SAMPLE_WIDTH-1:0] x0_im,
	input  logic signed [SAMPLE_WIDTH-1:0] x1_re,
	input  logic signed [SAMPLE_WIDTH-1:0] x1_im,
	input  logic signed [SAMPLE_WIDTH-1:0] x2_re,
	input  logic signed [SAMPLE_WIDTH-1:0] x2_im,
	input  logic signed [SAMPLE_WIDTH-1:0] x3_re,
	input  logic signed [SAMPLE_WIDTH-1:0] x3_im,
	input  logic signed [SAMPLE_WIDTH-1:0] x4_re,
	input  logic signed [SAMPLE_WIDTH-1:0] x4_im,
	input  logic                           batch_end_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [OUT_WIDTH-1:0]    y0_re,
	output logic signed [OUT_WIDTH-1:0]    y0_im,
	output logic signed [OUT_WIDTH-1:0]    y1_re,
	output logic signed [OUT_WIDTH-1:0]    y1_im,
	output logic signed [OUT_WIDTH-1:0]    y2_re,
	output logic signed [OUT_WIDTH-1:0]    y2_im,
	output logic signed [OUT_WIDTH-1:0]    y3_re,
	output logic signed [OUT_WIDTH-1:0]    y3_im,
	output logic signed [OUT_WIDTH-1:0]    y4_re,
	output logic signed [OUT_WIDTH-1:0]    y4_im,
	output logic                           batch_end_out
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	logic                           be_s1, be_s2, be_s3, be_s4;
	logic signed [SAMPLE_WIDTH-1:0] x0r_s1, x0i_s1, x0r_s2, x0i_s2;
	logic signed [SW1-1:0]          s14r_s1, s14i_s1, s23r_s1, s23i_s1;
	logic signed [SW1-1:0]          d41r_s1, d41i_s1, d32r_s1, d32i_s1;
	logic signed [SW1-1:0]          d41r_s2, d41i_s2, d32r_s2, d32i_s2;
	logic signed [SW2-1:0]          tr_s2, ti_s2, er_s2, ei_s2;
	logic signed [SW3-1:0]          y0r_s3, y0i_s3, cr_s3, ci_s3;
	logic signed [PW-1:0]           par_s3, pai_s3;
	logic signed [PW-1:0]           p2d41r_s3, p2d41i_s3, p4d41r_s3, p4d41i_s3;
	logic signed [PW-1:0]           p2d32r_s3, p2d32i_s3, p4d32r_s3, p4d32i_s3;
	logic signed [SW3-1:0]          y0r_s4, y0i_s4;
	logic signed [AW-1:0]           pr_s4, pi_s4, mr_s4, mi_s4;
	logic signed [AW-1:0]           u1_s4, v1_s4, u2_s4, v2_s4;

	assign en5      = !vld_s5 || !out_stall;
	assign en4      = !vld_s4 || en5;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// pairwise sums and differences
	always_ff @(posedge clk) begin
		if (en1) begin
			be_s1   <= batch_end_in;
			x0r_s1  <= x0_re;
			x0i_s1  <= x0_im;
			s14r_s1 <= SW1'(x1_re) + SW1'(x4_re);
			s14i_s1 <= SW1'(x1_im) + SW1'(x4_im);
			s23r_s1 <= SW1'(x2_re) + SW1'(x3_re);
			s23i_s1 <= SW1'(x2_im) + SW1'(x3_im);
			d41r_s1 <= SW1'(x4_re) - SW1'(x1_re);
			d41i_s1 <= SW1'(x4_im) - SW1'(x1_im);
			d32r_s1 <= SW1'(x3_re) - SW1'(x2_re);
			d32i_s1 <= SW1'(x3_im) - SW1'(x2_im);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			be_s2   <= be_s1;
			x0r_s2  <= x0r_s1;
			x0i_s2  <= x0i_s1;
			tr_s2   <= SW2'(s14r_s1) + SW2'(s23r_s1);
			ti_s2   <= SW2'(s14i_s1) + SW2'(s23i_s1);
			er_s2   <= SW2'(s14r_s1) - SW2'(s23r_s1);
			ei_s2   <= SW2'(s14i_s1) - SW2'(s23i_s1);
			d41r_s2 <= d41r_s1;
			d41i_s2 <= d41i_s1;
			d32r_s2 <= d32r_s1;
			d32i_s2 <= d32i_s1;
		end
	end

	// constant products, bin 0 and centre term
	always_ff @(posedge clk) begin
		if (en3) begin
			be_s3     <= be_s2;
			y0r_s3    <= SW3'(x0r_s2) + SW3'(tr_s2);
			y0i_s3    <= SW3'(x0i_s2) + SW3'(ti_s2);
			cr_s3     <= SW3'(x0r_s2) - SW3'(tr_s2 >>> 2);
			ci_s3     <= SW3'(x0i_s2) - SW3'(ti_s2 >>> 2);
			par_s3    <= kmul(er_s2, K1);
			pai_s3    <= kmul(ei_s2, K1);
			p2d41r_s3 <= kmul(SW2'(d41r_s2), K2);
			p2d41i_s3 <= kmul(SW2'(d41i_s2), K2);
			p4d41r_s3 <= kmul(SW2'(d41r_s2), K4);
			p4d41i_s3 <= kmul(SW2'(d41i_s2), K4);
			p2d32r_s3 <= kmul(SW2'(d32r_s2), K2);
			p2d32i_s3 <= kmul(SW2'(d32i_s2), K2);
			p4d32r_s3 <= kmul(SW2'(d32r_s2), K4);
			p4d32i_s3 <= kmul(SW2'(d32i_s2), K4);
		end
	end

	// round products, form cross terms
	always_ff @(posedge clk) begin
		if (en4) begin
			be_s4  <= be_s3;
			y0r_s4 <= y0r_s3;
			y0i_s4 <= y0i_s3;
			pr_s4  <= AW'(cr_s3) + AW'(qround(par_s3));
			pi_s4  <= AW'(ci_s3) + AW'(qround(pai_s3));
			mr_s4  <= AW'(cr_s3) - AW'(qround(par_s3));
			mi_s4  <= AW'(ci_s3) - AW'(qround(pai_s3));
			u1_s4  <= AW'(qround(p2d41i_s3)) + AW'(qround(p4d32i_s3));
			v1_s4  <= AW'(qround(p2d41r_s3)) + AW'(qround(p4d32r_s3));
			u2_s4  <= AW'(qround(p4d41i_s3)) - AW'(qround(p2d32i_s3));
			v2_s4  <= AW'(qround(p4d41r_s3)) - AW'(qround(p2d32r_s3));
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			batch_end_out <= be_s4;
			y0_re <= to_out(AW'(y0r_s4));
			y0_im <= to_out(AW'(y0i_s4));
			y1_re <= to_out(pr_s4 - u1_s4);
			y1_im <= to_out(pi_s4 + v1_s4);
			y2_re <= to_out(mr_s4 - u2_s4);
			y2_im <= to_out(mi_s4 + v2_s4);
			y3_re <= to_out(mr_s4 + u2_s4);
			y3_im <= to_out(mi_s4 - v2_s4);
			y4_re <= to_out(pr_s4 + u1_s4);
			y4_im <= to_out(pi_s4 - v1_s4);
		end
	end

	`R5_ASSERT(a_stall_only_when_full, in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_stall), "input stalled with a stage free")
	`R5_ASSERT(a_accept_loads_s1, (in_valid && !in_stall) |=> vld_s1, "accepted beat not held in first stage")
	`R5_ASSERT_RST(a_reset_empty, !arst_n |-> (!out_valid && !vld_s1 && !in_stall), "pipeline not empty in reset")

endmodule
